@@ rtl/rlrd_pkg.sv @@
`default_nettype none

package rlrd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned TotalW = 24;

  localparam logic [CountW-1:0] CountMax = 7'd127;
  localparam logic [TotalW-1:0] TotalMax = 24'hFF_FFFF;

  // Bit 7 of a header byte selects a repeat run.
  localparam int unsigned RunFlagBit = 7;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPVAL  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic [CountW-1:0] run_count;
    logic              stream_end;
    logic              truncated;
    logic [TotalW-1:0] decoded_total;
  } out_item_t;

  // Handshake between the input register and the decode stage.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/rlrd_in_stage.sv @@
`default_nettype none

module rlrd_in_stage
  import rlrd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output stage_t        stage,
  input  wire logic     consume
);

  logic     valid;
  in_item_t item;
  logic     accept;

  // The register can take a new item whenever it is empty or is being
  // drained in the same cycle.
  assign in_stall = valid && !consume;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

`default_nettype wire

@@ rtl/rlrd_decode.sv @@
`default_nettype none

module rlrd_decode
  import rlrd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire stage_t stage,
  output logic        consume,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_item
);

  phase_t            phase;
  phase_t            phase_next;
  logic [CountW-1:0] bytes_left;
  logic [CountW-1:0] bytes_left_next;
  logic [CountW-1:0] repeat_len;
  logic [CountW-1:0] repeat_len_next;
  logic [TotalW-1:0] total_count;
  logic [TotalW-1:0] total_next;
  logic [TotalW:0]   total_sum;
  logic [CountW-1:0] add_count;
  logic              tok;
  logic              emit;
  logic              last;
  logic [ByteW-1:0]  b;
  out_item_t         result;

  assign b       = stage.item.in_byte;
  assign last    = stage.item.in_last;
  assign consume = stage.valid && (!out_valid || !out_stall);

  always_comb begin
    phase_next      = PH_HEADER;
    bytes_left_next = bytes_left;
    repeat_len_next = repeat_len;
    tok             = 1'b0;
    add_count       = '0;
    case (phase)
      PH_REPVAL: begin
        tok             = (repeat_len != '0);
        add_count       = repeat_len;
        repeat_len_next = '0;
        phase_next      = PH_HEADER;
      end
      PH_LITERAL: begin
        tok             = 1'b1;
        add_count       = CountW'(1);
        bytes_left_next = bytes_left - CountW'(1);
        phase_next      = (bytes_left_next == '0) ? PH_HEADER : PH_LITERAL;
      end
      default: begin
        if (b[RunFlagBit]) begin
          repeat_len_next = b[CountW-1:0];
          phase_next      = PH_REPVAL;
        end else if (b[CountW-1:0] != '0) begin
          bytes_left_next = b[CountW-1:0];
          phase_next      = PH_LITERAL;
        end else begin
          phase_next = PH_HEADER;
        end
      end
    endcase

    total_sum  = {1'b0, total_count} + {{(TotalW + 1 - CountW){1'b0}}, add_count};
    total_next = (total_sum > {1'b0, TotalMax}) ? TotalMax : total_sum[TotalW-1:0];
    emit       = tok || last;

    result.out_byte      = tok ? b : '0;
    result.run_count     = tok ? add_count : '0;
    result.stream_end    = last;
    result.truncated     = last && (phase_next != PH_HEADER);
    result.decoded_total = total_next;
  end

  // A last byte returns every state field to its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      bytes_left  <= '0;
      repeat_len  <= '0;
      total_count <= '0;
    end else if (consume) begin
      if (last) begin
        phase       <= PH_HEADER;
        bytes_left  <= '0;
        repeat_len  <= '0;
        total_count <= '0;
      end else begin
        phase       <= phase_next;
        bytes_left  <= bytes_left_next;
        repeat_len  <= repeat_len_next;
        total_count <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rle_literal_repeat_decoder_top.sv @@
// Run-length token decoder for a byte stream of literal and repeat runs.
// Input channel: one coded byte per item on in_item (in_byte, in_last), taken
// at a rising edge with in_valid high and in_stall low. Output channel: run
// tokens on out_item, taken at an edge with out_valid high and out_stall low.
// A literal byte gives a token with run_count 1, a repeat run one token with
// its count; headers and zero-length runs give nothing, except that the item
// marked in_last always gives exactly one result carrying the saturating
// running total, stream_end and, if the stream stopped inside a run,
// truncated. After that item the decoder starts a fresh stream.
// Pipeline: an accepted item waits in the input register and is decoded into
// the output register when the decode stage consumes it.
// Throughput: one item per cycle while out_stall is low; the only loop is the
// registered state update of the decode stage. The input register is freed
// while the output register still holds a result only when that result is
// taken, so a stalled receiver backs up into in_stall after one more item.
// Reset: rst is synchronous; it empties both registers and returns the
// decoder to the header phase with a zero total.
`default_nettype none

module rle_literal_repeat_decoder_top
  import rlrd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  stage_t stage;
  logic   consume;

  rlrd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .stage    (stage),
    .consume  (consume)
  );

  rlrd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .consume   (consume),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_trunc_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.truncated |-> out_item.stream_end)
    else $error("truncated result without stream end");

  a_marker_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.run_count == '0) |->
      out_item.stream_end && (out_item.out_byte == '0))
    else $error("zero-count result that is not an end marker");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage.valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_end_restarts_total: assert property (@(posedge clk) disable iff (rst)
    consume && stage.item.in_last |=> u_decode.total_count == '0)
    else $error("total not cleared after stream end");
`endif

endmodule

`default_nettype wire
